### design/lpfp_pkg.sv
// Package for the length-prefixed frame parser core.
// Holds phase encoding, result kind codes, register indexes and reset values.
// No dependencies.
`default_nettype none

package lpfp_pkg;

   // Parser phase, one-hot
   typedef enum logic [4:0] {
      PH_HUNT    = 5'b00001,
      PH_LEN_LO  = 5'b00010,
      PH_LEN_HI  = 5'b00100,
      PH_PAYLOAD = 5'b01000,
      PH_CHECK   = 5'b10000
   } phase_type;

   // Result kinds
   localparam logic [1:0] KIND_DATA      = 2'd0;
   localparam logic [1:0] KIND_OK        = 2'd1;
   localparam logic [1:0] KIND_BAD_CHECK = 2'd2;
   localparam logic [1:0] KIND_TOO_LONG  = 2'd3;

   // Configuration register indexes
   localparam logic [1:0] REG_HEADER_VALUE    = 2'd0;
   localparam logic [1:0] REG_MAX_PAYLOAD_LEN = 2'd1;

   // Configuration reset values
   localparam logic [7:0]  HEADER_RESET  = 8'h2a;
   localparam logic [15:0] MAX_LEN_RESET = 16'd1024;

endpackage : lpfp_pkg

`default_nettype wire

### design/length_prefixed_frame_parser_core.sv
// Length-prefixed frame parser core: header hunt, little-endian length,
// payload pass-through and XOR check byte verdict.
// Depends on lpfp_pkg.
//
// Channel  Direction  Handshake              Payload
// req      in         req_tvalid/req_tready  tdata[7:0] rx_byte
// rsp      out        rsp_tvalid/rsp_tready  tdata[7:0] data_byte, [23:8] frame_len;
//                                            tuser[1:0] kind
// csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// One byte is accepted per cycle while req_tready is high; each result is registered
// straight from the accepted byte by the single phase/count/XOR update step.
// A result waiting in the output register does not block input as long as
// rsp_tready is high in the same cycle. Bytes causing no result leave no gap.
// Synchronous active-high reset returns to hunting with default registers.
// csr_ready is always high; writes are expected only while the core is idle.
`default_nettype none

module length_prefixed_frame_parser_core
   import lpfp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // input byte stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   // result stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [7:0] data_byte, [23:8] frame_len
   output logic [1:0]       rsp_tuser,   // [1:0] kind
   // configuration writes
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   phase_type   phase_ff, phase_in;
   logic [15:0] expected_length_ff, expected_length_in;
   logic [15:0] received_count_ff, received_count_in;
   logic [7:0]  running_check_ff, running_check_in;
   logic [7:0]  header_value_ff;
   logic [15:0] max_payload_len_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_kind_ff, rsp_kind_in;
   logic [7:0]  rsp_data_ff, rsp_data_in;
   logic [15:0] rsp_len_ff, rsp_len_in;

   logic        req_accept;
   logic        emit;
   logic [15:0] len_full;
   logic [15:0] count_next;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign len_full   = {req_tdata, expected_length_ff[7:0]};
   assign count_next = received_count_ff + 16'd1;

   // Configuration register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         header_value_ff    <= HEADER_RESET;
         max_payload_len_ff <= MAX_LEN_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_HEADER_VALUE:    header_value_ff    <= csr_data[7:0];
            REG_MAX_PAYLOAD_LEN: max_payload_len_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Next parser state and result for the incoming byte
   always_comb begin
      phase_in           = phase_ff;
      expected_length_in = expected_length_ff;
      received_count_in  = received_count_ff;
      running_check_in   = running_check_ff;
      emit               = 1'b0;
      rsp_kind_in        = KIND_DATA;
      rsp_data_in        = 8'd0;
      rsp_len_in         = 16'd0;
      case (phase_ff)
         PH_LEN_LO: begin
            expected_length_in = {8'd0, req_tdata};
            running_check_in   = running_check_ff ^ req_tdata;
            phase_in           = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            expected_length_in = len_full;
            running_check_in   = running_check_ff ^ req_tdata;
            received_count_in  = 16'd0;
            if (len_full > max_payload_len_ff) begin
               phase_in    = PH_HUNT;
               emit        = 1'b1;
               rsp_kind_in = KIND_TOO_LONG;
               rsp_len_in  = len_full;
            end else if (len_full == 16'd0) begin
               phase_in = PH_CHECK;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            running_check_in  = running_check_ff ^ req_tdata;
            received_count_in = count_next;
            if (count_next == expected_length_ff) begin
               phase_in = PH_CHECK;
            end
            emit        = 1'b1;
            rsp_kind_in = KIND_DATA;
            rsp_data_in = req_tdata;
         end
         PH_CHECK: begin
            phase_in    = PH_HUNT;
            emit        = 1'b1;
            rsp_kind_in = (running_check_ff == req_tdata) ? KIND_OK : KIND_BAD_CHECK;
            rsp_len_in  = received_count_ff;
         end
         default: begin
            // hunting, and any unexpected code
            phase_in = PH_HUNT;
            if (req_tdata == header_value_ff) begin
               running_check_in   = req_tdata;
               expected_length_in = 16'd0;
               received_count_in  = 16'd0;
               phase_in           = PH_LEN_LO;
            end
         end
      endcase
   end

   // Advance parser state on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_HUNT;
         expected_length_ff <= 16'd0;
         received_count_ff  <= 16'd0;
         running_check_ff   <= 8'd0;
      end else if (req_accept) begin
         phase_ff           <= phase_in;
         expected_length_ff <= expected_length_in;
         received_count_ff  <= received_count_in;
         running_check_ff   <= running_check_in;
      end
   end

   // Output register: load a new result or drop the one taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (req_accept) begin
         rsp_valid_in = emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && emit) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_data_ff <= rsp_data_in;
         rsp_len_ff  <= rsp_len_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_len_ff, rsp_data_ff};
   assign rsp_tuser  = rsp_kind_ff;

   // Checks
   a_phase_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(phase_ff))
      else $error("parser phase not one-hot");

   a_count_below_len: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> received_count_ff < expected_length_ff)
      else $error("payload count reached announced length while in payload");

   a_too_long: assert property (@(posedge clock) disable iff (reset)
      req_accept && phase_ff == PH_LEN_HI && len_full > max_payload_len_ff
      |=> phase_ff == PH_HUNT && rsp_tvalid && rsp_tuser == KIND_TOO_LONG)
      else $error("length error not reported or not back to hunting");

   a_check_verdict: assert property (@(posedge clock) disable iff (reset)
      req_accept && phase_ff == PH_CHECK
      |=> phase_ff == PH_HUNT && rsp_tvalid
          && (rsp_tuser == KIND_OK || rsp_tuser == KIND_BAD_CHECK))
      else $error("check byte did not give a verdict");

endmodule : length_prefixed_frame_parser_core

`default_nettype wire
